### hw/rtl/array_doubly_linked_list_macros.svh
// Assertion macros for the linked list block.
// Included by the checker; no other dependencies.
`ifndef ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH

// same-cycle implication, disabled during reset
`define ADLL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ADLL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/adll_pkg.sv
// Shared types and constants for the array based doubly linked list.
// No dependencies.
package adll_pkg;

   localparam int LinkW    = 10;
   localparam int NodesDef = 1023;

   typedef enum logic [1:0] {
      MODE_INS_RIGHT = 2'd0,
      MODE_INS_LEFT  = 2'd1,
      MODE_UNLINK    = 2'd2,
      MODE_QUERY     = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [LinkW-1:0]   anchor;
      logic [LinkW-1:0]   node;
   } req_type;

   typedef struct packed {
      logic [LinkW-1:0]   left_link;
      logic [LinkW-1:0]   right_link;
      logic               bad_id;
   } rsp_type;

   // id 0 means no neighbor; ids above the node count are rejected
   function automatic logic id_ok(logic [LinkW-1:0] id, int unsigned nodes);
      return (id != '0) && (32'(id) <= nodes);
   endfunction

endpackage

### hw/rtl/adll_ram.sv
// Link table memory: one write port, one read port, registered read data.
// Depends on adll_pkg for default widths.
module adll_ram import adll_pkg::*; #(
   parameter int Depth = NodesDef + 1,
   parameter int AddrW = $clog2(NodesDef + 1),
   parameter int DataW = LinkW
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [DataW-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [DataW-1:0] rd_data
);

   logic [DataW-1:0] mem [Depth];
   logic [DataW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/array_doubly_linked_list.sv
// Top level of the array based doubly linked list: sequencer over two link tables.
// Depends on adll_pkg and adll_ram.
//
//   port group   direction   handshake
//   req_data     in          taken when start is high and busy is low
//   rsp_data     out         valid for one cycle while rsp_valid is high
//
// Busy stays high until a multi-step item is through. Insert and unlink present their
// read address in the accept cycle, then write each single-write link table in ST_PH1
// and in ST_PH2; a query answers from ST_PH1, a bad id from idle. The result appears
// in the cycle after the last write. After reset a clearing pass zeroes both tables, busy held high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module array_doubly_linked_list import adll_pkg::*; #(
   parameter int NODES = NodesDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AddrW = $clog2(NODES + 1);
   localparam int Depth = NODES + 1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_PH1   = 4'b0100,
      ST_PH2   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [AddrW-1:0]  clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   req_type           op_ff, op_in;
   logic [LinkW-1:0]  hold_ff, hold_in;

   logic              accept, need_anchor, req_bad;
   logic [AddrW-1:0]  rd_addr;
   logic [LinkW-1:0]  rd_left, rd_right;
   logic              l_we, r_we;
   logic [AddrW-1:0]  l_waddr, r_waddr;
   logic [LinkW-1:0]  l_wdata, r_wdata;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign need_anchor = (req_data.mode == MODE_INS_RIGHT) || (req_data.mode == MODE_INS_LEFT);
   assign req_bad     = !id_ok(req_data.node, NODES)
                        || (need_anchor && !id_ok(req_data.anchor, NODES));
   assign rd_addr     = need_anchor ? AddrW'(req_data.anchor) : AddrW'(req_data.node);

   adll_ram #(.Depth(Depth), .AddrW(AddrW), .DataW(LinkW)) u_left (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_left)
   );

   adll_ram #(.Depth(Depth), .AddrW(AddrW), .DataW(LinkW)) u_right (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_right)
   );

   // table writes; each table takes its two writes in the order the list update needs
   always_comb begin
      l_we    = 1'b0;
      l_waddr = '0;
      l_wdata = '0;
      r_we    = 1'b0;
      r_waddr = '0;
      r_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            l_we    = 1'b1;
            l_waddr = clr_ff;
            r_we    = 1'b1;
            r_waddr = clr_ff;
         end
         ST_PH1: begin
            case (op_ff.mode)
               MODE_INS_RIGHT: begin
                  r_we    = 1'b1;
                  r_waddr = AddrW'(op_ff.anchor);
                  r_wdata = op_ff.node;
                  l_we    = 1'b1;
                  l_waddr = AddrW'(op_ff.node);
                  l_wdata = op_ff.anchor;
               end
               MODE_INS_LEFT: begin
                  l_we    = 1'b1;
                  l_waddr = AddrW'(op_ff.node);
                  l_wdata = rd_left;
                  r_we    = 1'b1;
                  r_waddr = AddrW'(op_ff.node);
                  r_wdata = op_ff.anchor;
               end
               MODE_UNLINK: begin
                  // bridge the neighbors over the node
                  r_we    = (rd_left != '0);
                  r_waddr = AddrW'(rd_left);
                  r_wdata = rd_right;
                  l_we    = (rd_right != '0);
                  l_waddr = AddrW'(rd_right);
                  l_wdata = rd_left;
               end
               default: begin
               end
            endcase
         end
         ST_PH2: begin
            case (op_ff.mode)
               MODE_INS_RIGHT: begin
                  r_we    = 1'b1;
                  r_waddr = AddrW'(op_ff.node);
                  r_wdata = hold_ff;
                  l_we    = (hold_ff != '0);
                  l_waddr = AddrW'(hold_ff);
                  l_wdata = op_ff.node;
               end
               MODE_INS_LEFT: begin
                  l_we    = 1'b1;
                  l_waddr = AddrW'(op_ff.anchor);
                  l_wdata = op_ff.node;
                  r_we    = (hold_ff != '0);
                  r_waddr = AddrW'(hold_ff);
                  r_wdata = op_ff.node;
               end
               MODE_UNLINK: begin
                  l_we    = 1'b1;
                  l_waddr = AddrW'(op_ff.node);
                  r_we    = 1'b1;
                  r_waddr = AddrW'(op_ff.node);
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // sequencer and result
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      hold_in      = hold_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AddrW'(NODES)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in = req_data;
               if (req_bad) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.left_link  = '0;
                  rsp_in.right_link = '0;
                  rsp_in.bad_id     = 1'b1;
               end else begin
                  state_in = ST_PH1;
               end
            end
         end
         ST_PH1: begin
            // keep the neighbor that the second write step patches
            hold_in = (op_ff.mode == MODE_INS_LEFT) ? rd_left : rd_right;
            if (op_ff.mode == MODE_QUERY) begin
               rsp_valid_in      = 1'b1;
               rsp_in.left_link  = rd_left;
               rsp_in.right_link = rd_right;
               rsp_in.bad_id     = 1'b0;
               state_in          = ST_IDLE;
            end else begin
               state_in = ST_PH2;
            end
         end
         ST_PH2: begin
            rsp_valid_in  = 1'b1;
            rsp_in.bad_id = 1'b0;
            state_in      = ST_IDLE;
            case (op_ff.mode)
               MODE_INS_RIGHT: begin
                  // the old right neighbor equal to the node overwrites its left link
                  rsp_in.left_link  = (hold_ff == op_ff.node) ? op_ff.node : op_ff.anchor;
                  rsp_in.right_link = hold_ff;
               end
               MODE_INS_LEFT: begin
                  rsp_in.left_link  = (op_ff.anchor == op_ff.node) ? op_ff.node : hold_ff;
                  rsp_in.right_link = (hold_ff == op_ff.node) ? op_ff.node : op_ff.anchor;
               end
               default: begin
                  rsp_in.left_link  = '0;
                  rsp_in.right_link = '0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/adll_checker.sv
// Port-level checks for the linked list block, bound to the top level.
// Depends on adll_pkg and array_doubly_linked_list_macros.svh.
`include "array_doubly_linked_list_macros.svh"

module adll_checker import adll_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic accept;

   assign accept = start && !busy;

   // an item either answers at once or keeps the block busy
   `ADLL_ASSERT_NEXT(a_accept_progress, clock, reset, accept, rsp_valid || busy, "item dropped")
   `ADLL_ASSERT_NEXT(a_zero_node_bad, clock, reset, accept && (req_data.node == '0), rsp_valid && rsp_data.bad_id, "node 0 not flagged")
   `ADLL_ASSERT_IMPL(a_bad_links_zero, clock, reset, rsp_valid && rsp_data.bad_id, (rsp_data.left_link == '0) && (rsp_data.right_link == '0), "bad item carries links")
   `ADLL_ASSERT_IMPL(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `ADLL_ASSERT_IMPL(a_clear_after_reset, clock, reset, $fell(reset), busy, "no clearing pass")

endmodule

bind array_doubly_linked_list adll_checker u_adll_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### tb/sv/adll_link_monitor.sv
// Watches the request and response channels of the linked list block, keeps its own
// copy of both link tables, and checks every response against the predicted links.
// Depends on adll_pkg for the request and response types and the operation codes.
`timescale 1ns / 1ps

module adll_link_monitor import adll_pkg::*; #(
   parameter int NODES = NodesDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding,
   output int      accepted,
   output int      rejected,
   output int      answered
);

   logic [LinkW-1:0] left_of  [0:(1<<LinkW)-1];
   logic [LinkW-1:0] right_of [0:(1<<LinkW)-1];
   rsp_type          expected_links[$];
   rsp_type          want;
   rsp_type          fresh;

   function automatic logic real_node(logic [LinkW-1:0] id);
      return id != '0 && int'(id) <= NODES;
   endfunction

   // update the shadow tables in the same write order as the hardware
   function automatic rsp_type apply_list_op(req_type it);
      rsp_type          res;
      logic [LinkW-1:0] k;
      logic [LinkW-1:0] x;
      logic [LinkW-1:0] nl;
      logic [LinkW-1:0] nr;
      logic             needs_anchor;
      res = '0;
      k = it.anchor;
      x = it.node;
      needs_anchor = (it.mode == MODE_INS_RIGHT) || (it.mode == MODE_INS_LEFT);
      if (!real_node(x) || (needs_anchor && !real_node(k))) begin
         res.bad_id = 1'b1;
         return res;
      end
      case (it.mode)
         MODE_INS_RIGHT: begin
            nr = right_of[k];
            right_of[k] = x;
            left_of[x] = k;
            right_of[x] = nr;
            if (real_node(nr)) left_of[nr] = x;
         end
         MODE_INS_LEFT: begin
            nl = left_of[k];
            left_of[x] = nl;
            right_of[x] = k;
            left_of[k] = x;
            if (real_node(nl)) right_of[nl] = x;
         end
         MODE_UNLINK: begin
            nl = left_of[x];
            nr = right_of[x];
            if (real_node(nl)) right_of[nl] = nr;
            if (real_node(nr)) left_of[nr] = nl;
            left_of[x] = '0;
            right_of[x] = '0;
         end
         default: ;
      endcase
      res.left_link  = left_of[x];
      res.right_link = right_of[x];
      return res;
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
      accepted    = 0;
      rejected    = 0;
      answered    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < (1 << LinkW); i++) begin
            left_of[i]  = '0;
            right_of[i] = '0;
         end
         expected_links.delete();
      end else begin
         // retire the oldest item before taking a new one on the same edge
         if (rsp_valid) begin
            if (expected_links.size() == 0) begin
               mismatches++;
               $display("%0t: response with nothing pending, got left %0d right %0d bad %0b",
                        $time, rsp_data.left_link, rsp_data.right_link, rsp_data.bad_id);
            end else begin
               want = expected_links.pop_front();
               answered++;
               if (rsp_data.left_link !== want.left_link ||
                   rsp_data.right_link !== want.right_link ||
                   rsp_data.bad_id !== want.bad_id) begin
                  mismatches++;
                  $display("%0t: mismatch, expected left %0d right %0d bad %0b, got left %0d right %0d bad %0b",
                           $time, want.left_link, want.right_link, want.bad_id,
                           rsp_data.left_link, rsp_data.right_link, rsp_data.bad_id);
               end
            end
         end
         if (start && !busy) begin
            fresh = apply_list_op(req_data);
            expected_links.push_back(fresh);
            accepted++;
            if (fresh.bad_id) rejected++;
         end
      end
      outstanding = expected_links.size();
   end

endmodule

### tb/sv/tb_array_doubly_linked_list.sv
// Stimulus and verdict for the linked list block: directed list operations, then
// random well-formed inserts, unlinks and queries mixed with noise. Depends on
// adll_pkg, the block array_doubly_linked_list and the monitor adll_link_monitor.
`timescale 1ns / 1ps

module tb_array_doubly_linked_list;
   import adll_pkg::*;

   localparam int RandomItems = 500;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int accepted;
   int rejected;
   int answered;

   logic             burst;
   logic             in_list[0:(1<<LinkW)-1];
   logic [LinkW-1:0] members[$];
   mode_type         all_modes[4] = '{MODE_INS_RIGHT, MODE_INS_LEFT, MODE_UNLINK, MODE_QUERY};

   array_doubly_linked_list dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   adll_link_monitor link_mon (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .accepted    (accepted),
      .rejected    (rejected),
      .answered    (answered)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // hold start high across back-to-back items; drop it only for a gap
   task automatic issue(mode_type m, logic [LinkW-1:0] k, logic [LinkW-1:0] x);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{mode: m, anchor: k, node: x};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [LinkW-1:0] any_id();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return LinkW'($urandom_range(1, 47));
         default: return LinkW'($urandom_range(0, (1 << LinkW) - 1));
      endcase
   endfunction

   function automatic logic [LinkW-1:0] unused_id();
      logic [LinkW-1:0] id;
      id = '0;
      for (int t = 0; t < 8; t++) begin
         if ($urandom_range(0, 7) == 0) id = LinkW'($urandom_range(1, (1 << LinkW) - 1));
         else id = LinkW'($urandom_range(1, 47));
         if (!in_list[id]) break;
      end
      return id;
   endfunction

   task automatic random_op();
      logic [LinkW-1:0] k;
      logic [LinkW-1:0] x;
      int               pick;
      int               idx;
      mode_type         ins_mode;
      pick = $urandom_range(0, 99);
      if (pick >= 80) begin
         // noise: any operation, ids anywhere including invalid ones
         issue(all_modes[$urandom_range(0, 3)], any_id(), any_id());
      end else if (members.size() < 2 || (pick < 45 && members.size() < 30)) begin
         x = unused_id();
         if (members.size() == 0) k = unused_id();
         else k = members[$urandom_range(0, members.size() - 1)];
         if (!in_list[k]) begin
            in_list[k] = 1'b1;
            members.push_back(k);
         end
         if (!in_list[x]) begin
            in_list[x] = 1'b1;
            members.push_back(x);
         end
         if (pick[0]) ins_mode = MODE_INS_LEFT;
         else ins_mode = MODE_INS_RIGHT;
         issue(ins_mode, k, x);
      end else if (pick < 65) begin
         idx = $urandom_range(0, members.size() - 1);
         x = members[idx];
         members.delete(idx);
         in_list[x] = 1'b0;
         issue(MODE_UNLINK, LinkW'($urandom_range(0, (1 << LinkW) - 1)), x);
      end else begin
         x = members[$urandom_range(0, members.size() - 1)];
         issue(MODE_QUERY, LinkW'($urandom_range(0, (1 << LinkW) - 1)), x);
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      burst    = 1'b0;
      for (int i = 0; i < (1 << LinkW); i++) in_list[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lone node after reset, rejected ids, ignored anchor
      issue(MODE_QUERY, '0, 1);
      issue(MODE_QUERY, '1, '0);
      issue(MODE_UNLINK, '0, '0);
      issue(MODE_INS_RIGHT, '0, 5);
      issue(MODE_INS_LEFT, 7, '0);
      issue(MODE_INS_LEFT, '0, '0);
      issue(MODE_UNLINK, '0, 9);
      // build 3 1 2 4 1023, then rewire it
      issue(MODE_INS_RIGHT, 1, 2);
      issue(MODE_INS_LEFT, 1, 3);
      issue(MODE_INS_RIGHT, 2, '1);
      issue(MODE_INS_LEFT, '1, 4);
      issue(MODE_QUERY, '1, 2);
      issue(MODE_INS_RIGHT, 2, 3);
      issue(MODE_INS_RIGHT, 5, 5);
      issue(MODE_INS_LEFT, 6, 6);
      issue(MODE_UNLINK, '1, 1);
      issue(MODE_UNLINK, '0, '1);
      issue(MODE_QUERY, '0, 4);
      issue(MODE_QUERY, 10'h2AA, 10'h155);
      issue(MODE_INS_RIGHT, 10'h155, 10'h2AA);
      issue(MODE_INS_LEFT, 10'h2AA, 10'h155);
      issue(MODE_UNLINK, 10'h155, 10'h2AA);

      for (int i = 0; i < RandomItems; i++) begin
         burst = ((i / 40) % 3) == 2;
         random_op();
      end

      start <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (8) @(posedge clock);

      $display("Covered %0d list operations (%0d with rejected ids) over all four modes,",
               accepted, rejected);
      $display("with %0d responses compared against the shadow link tables.", answered);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
